// ----- design/fwsr_pkg.sv -----
package fwsr_pkg;

  // Field widths of the channels and registers.
  localparam int COORD_W    = 11;
  localparam int DIM_W      = 12;
  localparam int OFS_W      = 16;
  localparam int AMT_W      = 16;
  localparam int IDX_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default largest frame dimension; larger register values are clamped to it.
  localparam int MAX_DIM_DEFAULT = 2048;

  // Remap modes. The unused code behaves as wrap.
  typedef enum logic [1:0] {
    MODE_WRAP      = 2'd0,
    MODE_SLIDE_IN  = 2'd1,
    MODE_SLIDE_OUT = 2'd2
  } mode_t;

  // Slide directions.
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REMAP_MODE      = 3'd0,
    REG_SLIDE_DIRECTION = 3'd1,
    REG_OFFSET_X        = 3'd2,
    REG_OFFSET_Y        = 3'd3,
    REG_SLIDE_AMOUNT    = 3'd4,
    REG_FRAME_WIDTH     = 3'd5,
    REG_FRAME_HEIGHT    = 3'd6
  } reg_idx_t;

endpackage

// ----- design/fwsr_in_if.sv -----
interface fwsr_in_if;
  logic                           valid;
  logic                           ready;
  logic [fwsr_pkg::COORD_W-1:0]   dest_x;
  logic [fwsr_pkg::COORD_W-1:0]   dest_y;

  modport source (output valid, output dest_x, output dest_y, input ready);
  modport sink   (input valid, input dest_x, input dest_y, output ready);
endinterface

// ----- design/fwsr_out_if.sv -----
interface fwsr_out_if;
  logic                           valid;
  logic                           ready;
  logic [fwsr_pkg::COORD_W-1:0]   source_x;
  logic [fwsr_pkg::COORD_W-1:0]   source_y;
  logic [fwsr_pkg::IDX_W-1:0]     source_index;
  logic                           zero_fill;

  modport source (output valid, output source_x, output source_y,
                  output source_index, output zero_fill, input ready);
  modport sink   (input valid, input source_x, input source_y,
                  input source_index, input zero_fill, output ready);
endinterface

// ----- design/fwsr_cfg_if.sv -----
interface fwsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fwsr_pkg::CFG_IDX_W-1:0]    index;
  logic [fwsr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/frame_wrap_slide_remap_unit.sv -----
// Channel    Direction  Payload
// cfg        sink       index, data (register write)
// coord_in   sink       dest_x, dest_y
// addr_out   source     source_x, source_y, source_index, zero_fill
//
// One coordinate is taken per cycle unless a stalled output holds a full
// pipeline; each result passes through a 7-register pipeline whose four
// middle stages each run four steps of a restoring remainder over a 16-bit
// dividend.
// rst is synchronous and clears the configuration registers and all stage valid bits.
// Each stage holds when the stage after it is full and stalled, so bubbles
// are filled while the output waits and nothing is dropped or repeated.
// Register writes are always accepted.
module frame_wrap_slide_remap_unit #(
  parameter int MAX_DIM = fwsr_pkg::MAX_DIM_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  fwsr_cfg_if.sink          cfg,
  fwsr_in_if.sink           coord_in,
  fwsr_out_if.source        addr_out
);
  import fwsr_pkg::*;

  localparam int SUM_W     = COORD_W + 6;          // x plus signed offset
  localparam int MAG_W     = SUM_W - 1;            // magnitude of that sum
  localparam int SLIDE_W   = AMT_W + 2;            // x plus or minus amount
  localparam int STEPS     = 4;                    // remainder steps per stage
  localparam int DIV_STG   = MAG_W / STEPS;
  localparam int FIX_STG   = DIV_STG + 1;
  localparam int NS        = DIV_STG + 3;
  localparam int PROD_W    = 2 * DIM_W;

  typedef struct packed {
    logic                      neg_x;
    logic                      neg_y;
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_y;
    logic [DIM_W-1:0]          rem_x;
    logic [DIM_W-1:0]          rem_y;
    logic [SLIDE_W-1:0]        slide_x;
    logic [SLIDE_W-1:0]        slide_y;
    logic [DIM_W-1:0]          src_x;
    logic [DIM_W-1:0]          src_y;
    logic                      fill;
    logic [IDX_W-1:0]          index;
  } pipe_t;

  // Configuration registers.
  logic [1:0]         remap_mode;
  dir_t               slide_direction;
  logic [OFS_W-1:0]   offset_x;
  logic [OFS_W-1:0]   offset_y;
  logic [AMT_W-1:0]   slide_amount;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic               is_slide;

  pipe_t              stage      [NS];
  pipe_t              stage_next [NS];
  logic [NS-1:0]      valid_pipe;
  logic [NS-1:0]      advance;

  // One remainder step: bring in the next dividend bit and subtract if it fits.
  function automatic logic [DIM_W-1:0] rem_step(input logic [DIM_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [DIM_W-1:0] dim);
    logic [DIM_W:0] shifted;
    shifted = {rem, bit_in};
    if (shifted >= {1'b0, dim}) begin
      shifted = shifted - {1'b0, dim};
    end
    return shifted[DIM_W-1:0];
  endfunction

  // Register writes; indexes beyond the list are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_mode      <= '0;
      slide_direction <= DIR_LEFT;
      offset_x        <= '0;
      offset_y        <= '0;
      slide_amount    <= '0;
      frame_width     <= '0;
      frame_height    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_REMAP_MODE:      remap_mode      <= cfg.data[1:0];
        REG_SLIDE_DIRECTION: slide_direction <= dir_t'(cfg.data[1:0]);
        REG_OFFSET_X:        offset_x        <= cfg.data[OFS_W-1:0];
        REG_OFFSET_Y:        offset_y        <= cfg.data[OFS_W-1:0];
        REG_SLIDE_AMOUNT:    slide_amount    <= cfg.data[AMT_W-1:0];
        REG_FRAME_WIDTH:     frame_width     <= cfg.data[DIM_W-1:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions clamped to the largest supported frame.
  assign w_eff = (32'(frame_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_width;
  assign h_eff = (32'(frame_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_height;
  assign is_slide = (remap_mode == MODE_SLIDE_IN) || (remap_mode == MODE_SLIDE_OUT);

  // Stage handshake: a stage loads when it is empty or its content moves on.
  always_comb begin
    advance[NS-1] = !valid_pipe[NS-1] || addr_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      advance[i] = !valid_pipe[i] || advance[i+1];
    end
  end

  assign coord_in.ready = advance[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      if (advance[0]) begin
        valid_pipe[0] <= coord_in.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (advance[i]) begin
          valid_pipe[i] <= valid_pipe[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (advance[i]) begin
        stage[i] <= stage_next[i];
      end
    end
  end

  // Entry stage: wrap sums split into sign and magnitude, slide coordinates.
  always_comb begin
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   neg_sum_x;
    logic [SUM_W-1:0]   neg_sum_y;
    logic [SLIDE_W-1:0] x_ext;
    logic [SLIDE_W-1:0] y_ext;
    logic [SLIDE_W-1:0] amt_ext;
    logic               fwd;
    sum_x     = {{(SUM_W-COORD_W){1'b0}}, coord_in.dest_x}
              + {{(SUM_W-OFS_W){offset_x[OFS_W-1]}}, offset_x};
    sum_y     = {{(SUM_W-COORD_W){1'b0}}, coord_in.dest_y}
              + {{(SUM_W-OFS_W){offset_y[OFS_W-1]}}, offset_y};
    neg_sum_x = '0 - sum_x;
    neg_sum_y = '0 - sum_y;
    x_ext     = {{(SLIDE_W-COORD_W){1'b0}}, coord_in.dest_x};
    y_ext     = {{(SLIDE_W-COORD_W){1'b0}}, coord_in.dest_y};
    amt_ext   = {{(SLIDE_W-AMT_W){1'b0}}, slide_amount};
    // Slide in toward a direction fetches from the opposite side.
    fwd       = (remap_mode == MODE_SLIDE_IN);

    stage_next[0]       = '0;
    stage_next[0].neg_x = sum_x[SUM_W-1];
    stage_next[0].neg_y = sum_y[SUM_W-1];
    stage_next[0].mag_x = sum_x[SUM_W-1] ? neg_sum_x[MAG_W-1:0] : sum_x[MAG_W-1:0];
    stage_next[0].mag_y = sum_y[SUM_W-1] ? neg_sum_y[MAG_W-1:0] : sum_y[MAG_W-1:0];
    stage_next[0].slide_x = x_ext;
    stage_next[0].slide_y = y_ext;
    unique case (slide_direction)
      DIR_LEFT:  stage_next[0].slide_x = fwd ? x_ext - amt_ext : x_ext + amt_ext;
      DIR_RIGHT: stage_next[0].slide_x = fwd ? x_ext + amt_ext : x_ext - amt_ext;
      DIR_UP:    stage_next[0].slide_y = fwd ? y_ext - amt_ext : y_ext + amt_ext;
      DIR_DOWN:  stage_next[0].slide_y = fwd ? y_ext + amt_ext : y_ext - amt_ext;
      default: ;
    endcase
  end

  // Remainder stages: each consumes the top STEPS bits of both magnitudes.
  for (genvar g = 1; g <= DIV_STG; g++) begin : g_div
    always_comb begin
      pipe_t p;
      p = stage[g-1];
      for (int j = 0; j < STEPS; j++) begin
        p.rem_x = rem_step(p.rem_x, p.mag_x[MAG_W-1], w_eff);
        p.rem_y = rem_step(p.rem_y, p.mag_y[MAG_W-1], h_eff);
        p.mag_x = {p.mag_x[MAG_W-2:0], 1'b0};
        p.mag_y = {p.mag_y[MAG_W-2:0], 1'b0};
      end
      stage_next[g] = p;
    end
  end

  // Select stage: sign fix of the remainder, or the slide bounds check.
  always_comb begin
    pipe_t            p;
    logic [DIM_W-1:0] wrap_x;
    logic [DIM_W-1:0] wrap_y;
    logic             out_x;
    logic             out_y;
    p = stage[FIX_STG-1];
    // A negative sum with a nonzero remainder folds back from the far edge.
    if (w_eff == '0) begin
      wrap_x = '0;
    end else if (p.neg_x && (p.rem_x != '0)) begin
      wrap_x = w_eff - p.rem_x;
    end else begin
      wrap_x = p.rem_x;
    end
    if (h_eff == '0) begin
      wrap_y = '0;
    end else if (p.neg_y && (p.rem_y != '0)) begin
      wrap_y = h_eff - p.rem_y;
    end else begin
      wrap_y = p.rem_y;
    end
    out_x = p.slide_x[SLIDE_W-1]
         || (p.slide_x[SLIDE_W-2:0] >= {{(SLIDE_W-1-DIM_W){1'b0}}, w_eff});
    out_y = p.slide_y[SLIDE_W-1]
         || (p.slide_y[SLIDE_W-2:0] >= {{(SLIDE_W-1-DIM_W){1'b0}}, h_eff});
    if (is_slide) begin
      p.fill  = out_x || out_y;
      p.src_x = p.fill ? '0 : p.slide_x[DIM_W-1:0];
      p.src_y = p.fill ? '0 : p.slide_y[DIM_W-1:0];
    end else begin
      p.fill  = 1'b0;
      p.src_x = wrap_x;
      p.src_y = wrap_y;
    end
    stage_next[FIX_STG] = p;
  end

  // Index stage: row times width plus column; zero when filling.
  always_comb begin
    pipe_t             p;
    logic [PROD_W-1:0] prod;
    p    = stage[NS-2];
    prod = p.src_y * w_eff + {{(PROD_W-DIM_W){1'b0}}, p.src_x};
    p.index = p.fill ? '0 : prod[IDX_W-1:0];
    stage_next[NS-1] = p;
  end

  // Output register drives the result channel.
  assign addr_out.valid        = valid_pipe[NS-1];
  assign addr_out.source_x     = stage[NS-1].src_x[COORD_W-1:0];
  assign addr_out.source_y     = stage[NS-1].src_y[COORD_W-1:0];
  assign addr_out.source_index = stage[NS-1].index;
  assign addr_out.zero_fill    = stage[NS-1].fill;

endmodule
